// File: hw/rtl/fupa_pkg.sv
// Package: constants, codes and types of the functional unit pool allocator.
package fupa_pkg;
	localparam int NumUnits   = 8;
	localparam int NumClasses = 16;
	localparam int UnitW      = 3;
	localparam int ClassW     = 4;
	localparam int LatW       = 7;
	localparam int CountW     = 4;
	localparam int AddrW      = UnitW + ClassW;

	typedef enum logic [1:0] {
		OP_DEFINE  = 2'd0,
		OP_REQUEST = 2'd1,
		OP_TICK    = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_GRANTED      = 3'd0,
		ST_BUSY         = 3'd1,
		ST_NOT_PROVIDED = 3'd2,
		ST_ACK          = 3'd3,
		ST_REJECT       = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE  = 2'd0,
		FSM_READ  = 2'd1,
		FSM_OUT   = 2'd2
	} fsm_t;

	localparam logic [ClassW-1:0] CLASS_MEM_READ  = 4'd10;
	localparam logic [ClassW-1:0] CLASS_MEM_WRITE = 4'd11;
	localparam logic [1:0]        REG_MEM_HIT     = 2'd0;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [UnitW-1:0]  unit_index;
		logic [ClassW-1:0] op_class;
		logic [LatW-1:0]   result_latency_in;
		logic [LatW-1:0]   issue_latency_in;
	} in_word_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [LatW-1:0]  result_latency;
		logic [UnitW-1:0] granted_unit;
	} out_word_t;
endpackage

// File: hw/rtl/fupa_stream_if.sv
// Interface: valid/ready channel carrying one word of a given type.
interface fupa_stream_if #(parameter type word_t = logic) ();
	logic  valid;
	logic  ready;
	word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/functional_unit_pool_allocator.sv
// Top level: functional unit pool allocator with latency memory.
// Each word passes accept, where defines write the latency memory and one entry
// (unit and class select it) is read into a register, then READ and OUT, where the
// result is registered; a new word is accepted in IDLE once the result register
// is empty or being taken. Ticks release due units in grant order, each to the
// free front. mem_hit_latency (byte address 0) overrides classes 10 and 11.
module functional_unit_pool_allocator
	import fupa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	fupa_stream_if.sink   in_ch,
	fupa_stream_if.source out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	// latency memory: {result, issue}
	logic [2*LatW-1:0] lat_mem [2**AddrW];
	logic [2*LatW-1:0] lat_rd_s1;

	logic [LatW-1:0]       mem_hit_q;
	logic [NumClasses-1:0] capable_q [NumUnits];
	logic [UnitW-1:0]      free_q [NumUnits];
	logic [CountW-1:0]     free_cnt_q;
	logic [UnitW-1:0]      busy_q [NumUnits];
	logic [CountW-1:0]     busy_cnt_q;
	logic [LatW:0]         cnt_q [NumUnits];

	fsm_t      state_q, state_d;
	in_word_t  word_q;
	out_word_t res_q;
	logic      res_vld_q;
	logic      [UnitW-1:0] pick_q;
	logic      [CountW-1:0] pick_pos_q;
	status_t   pick_st_q;

	logic accept, take;
	assign take   = out_ch.valid && out_ch.ready;
	assign accept = in_ch.valid && in_ch.ready;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr == REG_MEM_HIT) ? {25'd0, mem_hit_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_hit_q <= '0;
		end else if (psel && penable && pwrite && paddr == REG_MEM_HIT) begin
			mem_hit_q <= pwdata[LatW-1:0];
		end
	end

	// pick the first free capable unit
	logic [NumClasses-1:0] any_cap;
	logic                  found;
	logic [UnitW-1:0]      found_unit;
	logic [CountW-1:0]     found_pos;
	always_comb begin
		any_cap    = '0;
		found      = 1'b0;
		found_unit = '0;
		found_pos  = '0;
		for (int i = 0; i < NumUnits; i++) begin
			any_cap = any_cap | capable_q[i];
		end
		for (int i = 0; i < NumUnits; i++) begin
			if (!found && CountW'(i) < free_cnt_q &&
					capable_q[free_q[i]][in_ch.data.op_class]) begin
				found      = 1'b1;
				found_unit = free_q[i];
				found_pos  = CountW'(i);
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FSM_IDLE;
		else         state_q <= state_d;
	end
	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				in_ch.ready = !res_vld_q || take;
				if (accept) state_d = FSM_READ;
			end
			FSM_READ: state_d = FSM_OUT;
			FSM_OUT:  state_d = FSM_IDLE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	// latency memory access; hold the read word until the grant commits
	always_ff @(posedge clk) begin
		if (accept && in_ch.data.opcode == OP_DEFINE &&
				in_ch.data.result_latency_in != '0 && in_ch.data.issue_latency_in != '0) begin
			lat_mem[{in_ch.data.unit_index, in_ch.data.op_class}] <=
				{in_ch.data.result_latency_in, in_ch.data.issue_latency_in};
		end
		if (accept) begin
			lat_rd_s1 <= lat_mem[{found_unit, in_ch.data.op_class}];
		end
	end

	// word state, free/busy lists
	logic [UnitW-1:0]  nfree [NumUnits];
	logic [CountW-1:0] nfree_cnt;
	logic [UnitW-1:0]  nbusy [NumUnits];
	logic [CountW-1:0] nbusy_cnt;
	logic [LatW-1:0]   ilat;
	logic [LatW-1:0]   rlat;
	logic              grant_ok;
	assign grant_ok = word_q.opcode == OP_REQUEST && pick_st_q == ST_GRANTED;
	always_comb begin
		rlat = lat_rd_s1[2*LatW-1:LatW];
		ilat = lat_rd_s1[LatW-1:0];
		if (mem_hit_q != '0 &&
				(word_q.op_class == CLASS_MEM_READ || word_q.op_class == CLASS_MEM_WRITE))
			rlat = mem_hit_q;
		if (ilat == '0) ilat = LatW'(1);
	end

	always_comb begin
		nfree     = free_q;
		nfree_cnt = free_cnt_q;
		nbusy     = busy_q;
		nbusy_cnt = '0;
		for (int i = 0; i < NumUnits; i++) begin
			if (CountW'(i) < busy_cnt_q) begin
				if (cnt_q[busy_q[i]] <= (LatW+1)'(1)) begin
					for (int k = NumUnits - 1; k > 0; k--) nfree[k] = nfree[k-1];
					nfree[0]  = busy_q[i];
					nfree_cnt = nfree_cnt + 1'b1;
				end else begin
					nbusy[nbusy_cnt[UnitW-1:0]] = busy_q[i];
					nbusy_cnt = nbusy_cnt + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumUnits; i++) begin
				capable_q[i] <= '0;
				free_q[i]    <= UnitW'(i);
				busy_q[i]    <= '0;
				cnt_q[i]     <= '0;
			end
			free_cnt_q <= CountW'(NumUnits);
			busy_cnt_q <= '0;
			res_vld_q  <= 1'b0;
			pick_q     <= '0;
			pick_pos_q <= '0;
			pick_st_q  <= ST_ACK;
			word_q     <= '0;
			res_q      <= '0;
		end else begin
			if (take) res_vld_q <= 1'b0;
			if (accept) begin
				word_q <= in_ch.data;
				case (in_ch.data.opcode)
					OP_DEFINE: begin
						if (in_ch.data.result_latency_in != '0 &&
								in_ch.data.issue_latency_in != '0) begin
							capable_q[in_ch.data.unit_index][in_ch.data.op_class] <= 1'b1;
							pick_st_q <= ST_ACK;
						end else begin
							pick_st_q <= ST_REJECT;
						end
					end
					OP_REQUEST: begin
						pick_q     <= found_unit;
						pick_pos_q <= found_pos;
						if (!any_cap[in_ch.data.op_class]) pick_st_q <= ST_NOT_PROVIDED;
						else if (!found)                   pick_st_q <= ST_BUSY;
						else                               pick_st_q <= ST_GRANTED;
					end
					OP_TICK: begin
						pick_st_q <= ST_ACK;
						for (int i = 0; i < NumUnits; i++) begin
							if (CountW'(i) < busy_cnt_q) begin
								if (cnt_q[busy_q[i]] <= (LatW+1)'(1)) cnt_q[busy_q[i]] <= '0;
								else cnt_q[busy_q[i]] <= cnt_q[busy_q[i]] - 1'b1;
							end
						end
						free_q     <= nfree;
						free_cnt_q <= nfree_cnt;
						busy_q     <= nbusy;
						busy_cnt_q <= nbusy_cnt;
					end
					default: pick_st_q <= ST_ACK;
				endcase
			end
			// grant commits once the latencies are read
			if (state_q == FSM_OUT) begin
				res_vld_q <= 1'b1;
				res_q     <= '{status: pick_st_q,
					result_latency: grant_ok ? rlat : '0,
					granted_unit: grant_ok ? pick_q : '0};
				if (grant_ok) begin
					for (int k = 0; k < NumUnits - 1; k++) begin
						if (CountW'(k) >= pick_pos_q) free_q[k] <= free_q[k+1];
					end
					free_cnt_q <= free_cnt_q - 1'b1;
					busy_q[busy_cnt_q[UnitW-1:0]] <= pick_q;
					busy_cnt_q <= busy_cnt_q + 1'b1;
					cnt_q[pick_q] <= {1'b0, ilat};
				end
			end
		end
	end

	assign out_ch.valid = res_vld_q;
	assign out_ch.data  = res_q;

`ifndef SYNTH
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(free_cnt_q + busy_cnt_q) == CountW'(NumUnits))
		else $error("free and busy counts do not cover the pool");
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != FSM_IDLE) |-> !in_ch.ready)
		else $error("word accepted while another is in flight");
	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_OUT && pick_st_q == ST_GRANTED && word_q.opcode == OP_REQUEST)
		|-> free_cnt_q != '0)
		else $error("grant with empty free list");
`endif
endmodule
